FILE: sv/pwts_pkg.sv
package pwts_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int SIZE_W        = 14;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  // quotient bits kept by the divider; the term is capped at 2^(QW-1)
  localparam int QW            = 41;
  localparam int SUM_W         = QW + 3;

  localparam logic [SIZE_W-1:0] SCR_W_RST = SIZE_W'(2560);
  localparam logic [SIZE_W-1:0] SCR_H_RST = SIZE_W'(1440);
  localparam logic [QW-1:0]     TERM_CAP  = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_01,
    REG_ROW0_23,
    REG_ROW1_01,
    REG_ROW1_23,
    REG_ROW3_01,
    REG_ROW3_23,
    REG_SCR_W,
    REG_SCR_H
  } cfg_idx_t;

  // rows 0, 1 and 3 of the view matrix, four columns each
  typedef logic [2:0][3:0][COORD_W-1:0] mat_t;

  typedef struct packed {
    logic valid;
    logic behind;
    logic neg_x;
    logic neg_y;
    logic ov_x;
    logic ov_y;
  } ctl_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > $signed({{(SUM_W-COORD_W){1'b0}}, 1'b0, {(COORD_W-1){1'b1}}})) begin
      res = $signed({1'b0, {(COORD_W-1){1'b1}}});
    end else if (v < $signed({{(SUM_W-COORD_W){1'b1}}, 1'b1, {(COORD_W-1){1'b0}}})) begin
      res = $signed({1'b1, {(COORD_W-1){1'b0}}});
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/pwts_if.sv
interface pwts_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pwts_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic behind_camera;
  modport source (output valid, output screen_x, output screen_y, output behind_camera,
                  input ready);
  modport sink (input valid, input screen_x, input screen_y, input behind_camera,
                output ready);
endinterface

interface pwts_cfg_if;
  logic valid;
  logic ready;
  logic [3:0] index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/pwts_clip.sv
module pwts_clip #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [31:0]             pos_x,
  input  logic signed [31:0]             pos_y,
  input  logic signed [31:0]             pos_z,
  input  pwts_pkg::mat_t                 mat,
  output pwts_pkg::ctl_t                 ctl,
  output logic [64-FRAC_BITS:0]          mag_x,
  output logic [64-FRAC_BITS:0]          mag_y,
  output logic [65-FRAC_BITS:0]          d
);
  import pwts_pkg::*;

  localparam int CW  = 66 - FRAC_BITS;
  // w*100 < 2^F  <=>  w < ceil(2^F / 100)
  localparam int LIM = ((1 << FRAC_BITS) + 99) / 100;

  logic signed [63:0]   prod_r [3][3];
  logic signed [CW-1:0] c_r [3];
  logic signed [CW-1:0] c_nxt [3];
  logic signed [31:0]   pos [3];
  logic                 va_r, vb_r;
  ctl_t                 ctl_r, ctl_nxt;
  logic [CW-2:0]        mx_r, my_r, mx_nxt, my_nxt;
  logic [CW-1:0]        d_r, d_nxt;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= $signed(mat[r][c]) * pos[c];
        end
        c_r[r] <= c_nxt[r];
      end
      mx_r <= mx_nxt;
      my_r <= my_nxt;
      d_r  <= d_nxt;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c_nxt[r] = CW'($signed(mat[r][3]));
      for (int c = 0; c < 3; c++) begin
        // arithmetic shift is the floor
        c_nxt[r] = c_nxt[r] + CW'(prod_r[r][c] >>> FRAC_BITS);
      end
    end
  end

  always_comb begin
    ctl_nxt        = '0;
    ctl_nxt.valid  = vb_r;
    ctl_nxt.behind = c_r[2] < $signed(CW'(LIM));
    ctl_nxt.neg_x  = c_r[0][CW-1];
    ctl_nxt.neg_y  = c_r[1][CW-1];
    mx_nxt = c_r[0][CW-1] ? (CW-1)'(-c_r[0]) : (CW-1)'(c_r[0]);
    my_nxt = c_r[1][CW-1] ? (CW-1)'(-c_r[1]) : (CW-1)'(c_r[1]);
    d_nxt  = {c_r[2][CW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      ctl_r <= '0;
    end else if (en) begin
      va_r  <= in_valid;
      vb_r  <= va_r;
      ctl_r <= ctl_nxt;
    end
  end

  assign ctl   = ctl_r;
  assign mag_x = mx_r;
  assign mag_y = my_r;
  assign d     = d_r;

endmodule

FILE: sv/pwts_div.sv
module pwts_div #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  pwts_pkg::ctl_t                ctl_in,
  input  logic [64-FRAC_BITS:0]         mag_x,
  input  logic [64-FRAC_BITS:0]         mag_y,
  input  logic [65-FRAC_BITS:0]         d_in,
  input  logic [pwts_pkg::SIZE_W-1:0]   scr_w,
  input  logic [pwts_pkg::SIZE_W-1:0]   scr_h,
  output pwts_pkg::ctl_t                ctl_out,
  output logic [pwts_pkg::QW-1:0]       qx,
  output logic [pwts_pkg::QW-1:0]       qy
);
  import pwts_pkg::*;

  localparam int CW = 66 - FRAC_BITS;
  localparam int MW = CW - 1;
  localparam int NW = MW + SIZE_W + FRAC_BITS;

  // numerator stage
  ctl_t                  ctln_r;
  logic [NW-1:0]         nx_r, ny_r;
  logic [CW-1:0]         dn_r;

  // restoring divider, stage 0 is the setup, one quotient bit per stage after it
  ctl_t                  ctl_r  [0:QW];
  logic [CW-1:0]         d_r    [0:QW];
  logic [CW-1:0]         rx_r   [0:QW];
  logic [CW-1:0]         ry_r   [0:QW];
  logic [QW-1:0]         lx_r   [0:QW];
  logic [QW-1:0]         ly_r   [0:QW];
  logic [QW-1:0]         qx_r   [0:QW];
  logic [QW-1:0]         qy_r   [0:QW];
  logic [CW-1:0]         rx_nxt [0:QW];
  logic [CW-1:0]         ry_nxt [0:QW];
  logic [QW-1:0]         qx_nxt [0:QW];
  logic [QW-1:0]         qy_nxt [0:QW];
  ctl_t                  ctl0_nxt;
  logic [NW-QW-1:0]      hx, hy;

  function automatic logic [CW:0] div_step(input logic [CW-1:0] r, input logic b,
                                           input logic [CW-1:0] dv);
    logic [CW:0] rs;
    logic        ge;
    rs = {r, b};
    ge = rs >= {1'b0, dv};
    return {ge, ge ? CW'(rs - {1'b0, dv}) : CW'(rs)};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= {(NW - FRAC_BITS)'(mag_x * scr_w), {FRAC_BITS{1'b0}}};
      ny_r <= {(NW - FRAC_BITS)'(mag_y * scr_h), {FRAC_BITS{1'b0}}};
      dn_r <= d_in;
    end
  end

  assign hx = nx_r[NW-1:QW];
  assign hy = ny_r[NW-1:QW];

  always_comb begin
    ctl0_nxt      = ctln_r;
    // quotient of 2^QW or more is past the cap anyway
    ctl0_nxt.ov_x = NW'(hx) >= NW'(dn_r);
    ctl0_nxt.ov_y = NW'(hy) >= NW'(dn_r);
    rx_nxt[0] = CW'(hx);
    ry_nxt[0] = CW'(hy);
    qx_nxt[0] = '0;
    qy_nxt[0] = '0;
    for (int k = 1; k <= QW; k++) begin
      {qx_nxt[k][0], rx_nxt[k]} = div_step(rx_r[k-1], lx_r[k-1][QW-1], d_r[k-1]);
      {qy_nxt[k][0], ry_nxt[k]} = div_step(ry_r[k-1], ly_r[k-1][QW-1], d_r[k-1]);
      qx_nxt[k][QW-1:1] = qx_r[k-1][QW-2:0];
      qy_nxt[k][QW-1:1] = qy_r[k-1][QW-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]  <= dn_r;
      lx_r[0] <= nx_r[QW-1:0];
      ly_r[0] <= ny_r[QW-1:0];
      for (int k = 0; k <= QW; k++) begin
        rx_r[k] <= rx_nxt[k];
        ry_r[k] <= ry_nxt[k];
        qx_r[k] <= qx_nxt[k];
        qy_r[k] <= qy_nxt[k];
      end
      for (int k = 1; k <= QW; k++) begin
        d_r[k]  <= d_r[k-1];
        lx_r[k] <= {lx_r[k-1][QW-2:0], 1'b0};
        ly_r[k] <= {ly_r[k-1][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctln_r <= '0;
      for (int k = 0; k <= QW; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      ctln_r   <= ctl_in;
      ctl_r[0] <= ctl0_nxt;
      for (int k = 1; k <= QW; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  assign ctl_out = ctl_r[QW];
  assign qx      = qx_r[QW];
  assign qy      = qy_r[QW];

endmodule

FILE: sv/perspective_world_to_screen.sv
// Pipeline: 3 clip stages, 1 numerator stage, 1 divider setup, 41 one-bit
// divider stages and 1 output register, from input request to result.
// Throughput: one point per cycle unless the output stalls; the 41-stage
// restoring divider sets depth. A stalled output freezes the whole pipeline;
// nothing is dropped. Reset (synchronous, rst_n low) clears all valid bits,
// zeroes the matrix and sets the viewport to 2560 x 1440.
module perspective_world_to_screen #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  pwts_in_if.sink    in_ch,
  pwts_out_if.source out_ch,
  pwts_cfg_if.sink   cfg_ch
);
  import pwts_pkg::*;

  localparam int CW = 66 - FRAC_BITS;

  logic [CFG_DATA_W-1:0] mreg_r [6];
  logic [SIZE_W-1:0]     scr_w_r, scr_h_r;
  mat_t                  mat;
  logic                  en;
  ctl_t                  ctl_c, ctl_d;
  logic [CW-2:0]         mag_x, mag_y;
  logic [CW-1:0]         dv;
  logic [QW-1:0]         qx, qy, tx, ty;
  logic signed [SUM_W-1:0] sx, sy, stx, sty, wh, hh, half;
  logic                  out_valid_r;
  logic signed [31:0]    sx_r, sy_r, sx_nxt, sy_nxt;
  logic                  beh_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        mreg_r[i] <= '0;
      end
      scr_w_r <= SCR_W_RST;
      scr_h_r <= SCR_H_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_idx_t'(cfg_ch.index))
        REG_ROW0_01: mreg_r[0] <= cfg_ch.data;
        REG_ROW0_23: mreg_r[1] <= cfg_ch.data;
        REG_ROW1_01: mreg_r[2] <= cfg_ch.data;
        REG_ROW1_23: mreg_r[3] <= cfg_ch.data;
        REG_ROW3_01: mreg_r[4] <= cfg_ch.data;
        REG_ROW3_23: mreg_r[5] <= cfg_ch.data;
        REG_SCR_W:   scr_w_r   <= cfg_ch.data[SIZE_W-1:0];
        REG_SCR_H:   scr_h_r   <= cfg_ch.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = mreg_r[2*r][63:32];
      mat[r][1] = mreg_r[2*r][31:0];
      mat[r][2] = mreg_r[2*r+1][63:32];
      mat[r][3] = mreg_r[2*r+1][31:0];
    end
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  pwts_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .pos_x    (in_ch.pos_x),
    .pos_y    (in_ch.pos_y),
    .pos_z    (in_ch.pos_z),
    .mat      (mat),
    .ctl      (ctl_c),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .d        (dv)
  );

  pwts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (ctl_c),
    .mag_x   (mag_x),
    .mag_y   (mag_y),
    .d_in    (dv),
    .scr_w   (scr_w_r),
    .scr_h   (scr_h_r),
    .ctl_out (ctl_d),
    .qx      (qx),
    .qy      (qy)
  );

  always_comb begin
    tx   = (ctl_d.ov_x || qx > TERM_CAP) ? TERM_CAP : qx;
    ty   = (ctl_d.ov_y || qy > TERM_CAP) ? TERM_CAP : qy;
    stx  = ctl_d.neg_x ? -$signed(SUM_W'(tx)) : $signed(SUM_W'(tx));
    sty  = ctl_d.neg_y ? -$signed(SUM_W'(ty)) : $signed(SUM_W'(ty));
    half = $signed(SUM_W'(1) << (FRAC_BITS - 1));
    wh   = $signed(SUM_W'(scr_w_r) << (FRAC_BITS - 1));
    hh   = $signed(SUM_W'(scr_h_r) << (FRAC_BITS - 1));
    sx   = wh + stx + half;
    sy   = hh - (sty + half);
    sx_nxt = ctl_d.behind ? '0 : sat32(sx);
    sy_nxt = ctl_d.behind ? '0 : sat32(sy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      beh_r <= ctl_d.behind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_d.valid;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.screen_x      = sx_r;
  assign out_ch.screen_y      = sy_r;
  assign out_ch.behind_camera = beh_r;

`ifndef NO_ASSERTIONS
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.behind_camera |-> out_ch.screen_x == 0 && out_ch.screen_y == 0)
    else $error("behind-camera result not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("request taken while output stalled");
`endif

endmodule
